FILE: rtl/iee_pkg.sv
`default_nettype none

package iee_pkg;

   // operator that joins the current term and the literal being read
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_MUL  = 2'd1,
      OP_DIV  = 2'd2
   } op_type;

   // what an input character asks for
   typedef enum logic [2:0] {
      CLS_OTHER = 3'd0,
      CLS_DIGIT = 3'd1,
      CLS_MUL   = 3'd2,
      CLS_DIV   = 3'd3,
      CLS_ADD   = 3'd4,
      CLS_SUB   = 3'd5,
      CLS_EQ    = 3'd6
   } cls_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_FIN   = 2'd2,
      ST_APPLY = 2'd3
   } state_type;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_EQUAL = 8'h3d;

   // controller to datapath
   typedef struct packed {
      logic   digit;
      logic   start_mul;
      logic   start_div;
      logic   step;
      logic   fold_number;
      logic   set_pend;
      logic   fold_term;
      logic   emit;
      op_type new_pend;
      logic   neg;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type pend;
      logic   number_zero;
      logic   last_step;
   } status_type;

   // space and anything unknown fall into the ignore class
   function automatic cls_type char_class(input logic [7:0] ch);
      cls_type c;
      c = CLS_OTHER;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         c = CLS_DIGIT;
      end else begin
         case (ch)
            CH_STAR:  c = CLS_MUL;
            CH_SLASH: c = CLS_DIV;
            CH_PLUS:  c = CLS_ADD;
            CH_MINUS: c = CLS_SUB;
            CH_EQUAL: c = CLS_EQ;
            default:  c = CLS_OTHER;
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/iee_ctrl.sv
`default_nettype none

module iee_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire  [7:0]          req_tdata,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  iee_pkg::status_type status,
   output iee_pkg::cmd_type    cmd
);

   iee_pkg::state_type state_ff, state_in;
   iee_pkg::cls_type   cls_ff, cls_in, cls_now;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign cls_now    = iee_pkg::char_class(req_tdata);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iee_pkg::ST_IDLE;
         cls_ff       <= iee_pkg::CLS_OTHER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cls_ff       <= cls_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cls_in     = cls_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         iee_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cls_in = cls_now;
               if (cls_now == iee_pkg::CLS_DIGIT) begin
                  cmd.digit = 1'b1;
               end else if (cls_now inside {iee_pkg::CLS_MUL, iee_pkg::CLS_DIV,
                                            iee_pkg::CLS_ADD, iee_pkg::CLS_SUB,
                                            iee_pkg::CLS_EQ}) begin
                  // operator: first fold the literal into the term
                  if (status.pend == iee_pkg::OP_MUL) begin
                     cmd.start_mul = 1'b1;
                     state_in      = iee_pkg::ST_RUN;
                  end else if (status.pend == iee_pkg::OP_DIV && !status.number_zero) begin
                     cmd.start_div = 1'b1;
                     state_in      = iee_pkg::ST_RUN;
                  end else begin
                     state_in = iee_pkg::ST_FIN;
                  end
               end
            end
         end
         iee_pkg::ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = iee_pkg::ST_FIN;
            end
         end
         iee_pkg::ST_FIN: begin
            cmd.fold_number = 1'b1;
            state_in        = iee_pkg::ST_APPLY;
         end
         iee_pkg::ST_APPLY: begin
            state_in = iee_pkg::ST_IDLE;
            case (cls_ff)
               iee_pkg::CLS_MUL: begin
                  cmd.set_pend = 1'b1;
                  cmd.new_pend = iee_pkg::OP_MUL;
               end
               iee_pkg::CLS_DIV: begin
                  cmd.set_pend = 1'b1;
                  cmd.new_pend = iee_pkg::OP_DIV;
               end
               iee_pkg::CLS_ADD: begin
                  cmd.fold_term = 1'b1;
               end
               iee_pkg::CLS_SUB: begin
                  cmd.fold_term = 1'b1;
                  cmd.neg       = 1'b1;
               end
               iee_pkg::CLS_EQ: begin
                  // hold here until the output register can take the word
                  if (slot_free) begin
                     cmd.emit = 1'b1;
                  end else begin
                     state_in = iee_pkg::ST_APPLY;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = iee_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   a_emit_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken word");

   a_start_run : assert property (@(posedge clock) disable iff (reset)
      (cmd.start_mul || cmd.start_div) |=> state_ff == iee_pkg::ST_RUN)
      else $error("iterative unit started without entering run");

   a_run_fin : assert property (@(posedge clock) disable iff (reset)
      (state_ff == iee_pkg::ST_RUN && status.last_step) |=> state_ff == iee_pkg::ST_FIN)
      else $error("run did not end in fold");

   // a result held back by a stalled output is emitted while the controller stays in the apply state
   a_fold_before_apply : assert property (@(posedge clock) disable iff (reset)
      (cmd.fold_term || cmd.set_pend || cmd.emit) |->
         ($past(cmd.fold_number) || $past(state_ff) == iee_pkg::ST_APPLY))
      else $error("term updated without a literal fold");

endmodule

`default_nettype wire

FILE: rtl/iee_dpath.sv
`default_nettype none

module iee_dpath #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [7:0]          req_tdata,
   input  iee_pkg::cmd_type    cmd,
   output iee_pkg::status_type status,
   output logic [31:0]         rsp_tdata,
   output logic [0:0]          rsp_tuser
);

   localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic [VALUE_WIDTH-1:0] sum_ff, sum_in;
   logic [VALUE_WIDTH-1:0] term_ff, term_in;
   logic [VALUE_WIDTH-1:0] number_ff, number_in;
   logic                   neg_ff, neg_in;
   iee_pkg::op_type        pend_ff, pend_in;
   logic                   err_ff, err_in;

   // shared shift/add unit: a is multiplicand or dividend/quotient,
   // b is multiplier or divisor magnitude, p is product or remainder
   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic [VALUE_WIDTH-1:0] p_ff, p_in;
   logic                   negq_ff, negq_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic [31:0]            out_value_ff, out_value_in;
   logic                   out_err_ff, out_err_in;

   logic [VALUE_WIDTH-1:0] term_mag, number_mag, sum_next;
   logic [VALUE_WIDTH:0]   trial;
   logic                   term_sign, number_sign;

   assign term_sign   = term_ff[VALUE_WIDTH-1];
   assign number_sign = number_ff[VALUE_WIDTH-1];
   assign term_mag    = term_sign ? (~term_ff + 1'b1) : term_ff;
   assign number_mag  = number_sign ? (~number_ff + 1'b1) : number_ff;
   assign sum_next    = neg_ff ? (sum_ff - term_ff) : (sum_ff + term_ff);
   assign trial       = {p_ff, a_ff[VALUE_WIDTH-1]} - {1'b0, b_ff};

   assign status.pend        = pend_ff;
   assign status.number_zero = (number_ff == '0);
   assign status.last_step   = (cnt_ff == '0);

   assign rsp_tdata = out_value_ff;
   assign rsp_tuser = out_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         term_ff   <= '0;
         number_ff <= '0;
         neg_ff    <= 1'b0;
         pend_ff   <= iee_pkg::OP_NONE;
         err_ff    <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         term_ff   <= term_in;
         number_ff <= number_in;
         neg_ff    <= neg_in;
         pend_ff   <= pend_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      p_ff         <= p_in;
      negq_ff      <= negq_in;
      cnt_ff       <= cnt_in;
      out_value_ff <= out_value_in;
      out_err_ff   <= out_err_in;
   end

   always_comb begin
      sum_in       = sum_ff;
      term_in      = term_ff;
      number_in    = number_ff;
      neg_in       = neg_ff;
      pend_in      = pend_ff;
      err_in       = err_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      p_in         = p_ff;
      negq_in      = negq_ff;
      cnt_in       = cnt_ff;
      out_value_in = out_value_ff;
      out_err_in   = out_err_ff;

      // times ten as two shifts and an add, digit value is the low nibble
      if (cmd.digit) begin
         number_in = (number_ff << 3) + (number_ff << 1)
                   + VALUE_WIDTH'(req_tdata[3:0]);
      end

      if (cmd.start_mul) begin
         a_in   = term_ff;
         b_in   = number_ff;
         p_in   = '0;
         cnt_in = CNT_W'(VALUE_WIDTH - 1);
      end

      if (cmd.start_div) begin
         a_in    = term_mag;
         b_in    = number_mag;
         p_in    = '0;
         negq_in = term_sign ^ number_sign;
         cnt_in  = CNT_W'(VALUE_WIDTH - 1);
      end

      if (cmd.step) begin
         cnt_in = cnt_ff - 1'b1;
         case (pend_ff)
            iee_pkg::OP_MUL: begin
               if (b_ff[0]) begin
                  p_in = p_ff + a_ff;
               end
               a_in = a_ff << 1;
               b_in = b_ff >> 1;
            end
            iee_pkg::OP_DIV: begin
               // restoring step, remainder stays below the divisor
               if (!trial[VALUE_WIDTH]) begin
                  p_in = trial[VALUE_WIDTH-1:0];
                  a_in = {a_ff[VALUE_WIDTH-2:0], 1'b1};
               end else begin
                  p_in = {p_ff[VALUE_WIDTH-2:0], a_ff[VALUE_WIDTH-1]};
                  a_in = {a_ff[VALUE_WIDTH-2:0], 1'b0};
               end
            end
            default: ;
         endcase
      end

      if (cmd.fold_number) begin
         case (pend_ff)
            iee_pkg::OP_MUL: term_in = p_ff;
            iee_pkg::OP_DIV: begin
               if (number_ff == '0) begin
                  err_in  = 1'b1;
                  term_in = '0;
               end else begin
                  term_in = negq_ff ? (~a_ff + 1'b1) : a_ff;
               end
            end
            default: term_in = number_ff;
         endcase
         number_in = '0;
      end

      if (cmd.set_pend) begin
         pend_in = cmd.new_pend;
      end

      if (cmd.fold_term) begin
         sum_in  = sum_next;
         term_in = '0;
         pend_in = iee_pkg::OP_NONE;
         neg_in  = cmd.neg;
      end

      // end of expression: load the result word and start afresh
      if (cmd.emit) begin
         out_value_in = err_ff ? 32'd0 : 32'($signed(sum_next));
         out_err_in   = err_ff;
         sum_in       = '0;
         term_in      = '0;
         number_in    = '0;
         neg_in       = 1'b0;
         pend_in      = iee_pkg::OP_NONE;
         err_in       = 1'b0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/infix_expression_evaluator_core.sv
`default_nettype none

// channel   direction  ports                      word
// req       in         req_tvalid/tready/tdata    tdata[7:0] ch
// rsp       out        rsp_tvalid/tready/tdata    tdata[31:0] value, tuser[0] div_by_zero
//
// a digit, space or ignored character is taken in the idle state, which it does not leave
// an operator after no pending '*' or '/', or after a '/' with a zero divisor,
// passes the fold and apply states; after a pending '*' or a '/' with a non-zero
// divisor it runs the shared shift-add / restoring-divide unit first; the unit
// retires one bit a cycle
// reset clears the accumulators, the pending operator and the output valid
// a stalled result word is held in the output register; input keeps flowing
// until the next '=' finds the register still full

module infix_expression_evaluator_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // ch
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // value
   output logic [0:0]  rsp_tuser    // div_by_zero
);

   // command and status between controller and datapath
   iee_pkg::cmd_type    cmd;
   iee_pkg::status_type status;

   // controller: sequences literal folds, the iterative unit and result hand-off
   iee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: accumulators, multiply/divide unit and output register
   iee_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire
